// ===== rtl/lav_pkg.sv =====
package lav_pkg;

  // field widths
  localparam int CW = 32;            // Q16.16 coordinate
  localparam int UW = 18;            // Q1.16 unit component
  localparam int FRAC = 16;
  localparam int DIR_W = CW + 1;     // target - eye
  localparam int PROD_W = 2 * UW;    // Q3.32 cross product term
  localparam int CROSS_W = PROD_W + 1;
  localparam int DOT_P_W = UW + CW;  // row component times eye component
  localparam int DOT_W = DOT_P_W + 3;

  // normaliser internals
  localparam int LZ_STEPS = 6;       // covers vectors up to 64 bits wide
  localparam int MANT_W = 31;        // largest magnitude scaled into [2^30, 2^31)
  localparam int SUM_W = 64;
  localparam int LEN_W = 32;
  localparam int SQRT_STEPS = 32;
  localparam int NUM_W = MANT_W + FRAC + 1;
  localparam int DIV_STEPS = UW;

  localparam logic [UW-1:0] ONE_Q16 = UW'(65536);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [UW-1:0] unit_t;

endpackage

// ===== rtl/lav_if.sv =====
// input word: eye, target and up hint
interface lav_in_if;
  logic            valid;
  logic            ready;
  lav_pkg::coord_t eye_x;
  lav_pkg::coord_t eye_y;
  lav_pkg::coord_t eye_z;
  lav_pkg::coord_t target_x;
  lav_pkg::coord_t target_y;
  lav_pkg::coord_t target_z;
  lav_pkg::coord_t upvec_x;
  lav_pkg::coord_t upvec_y;
  lav_pkg::coord_t upvec_z;

  modport source (
    output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
           upvec_x, upvec_y, upvec_z,
    input  ready
  );
  modport sink (
    input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
           upvec_x, upvec_y, upvec_z,
    output ready
  );
endinterface

// result word: rotation rows and translation
interface lav_out_if;
  logic            valid;
  logic            ready;
  lav_pkg::unit_t  side_x;
  lav_pkg::unit_t  side_y;
  lav_pkg::unit_t  side_z;
  lav_pkg::unit_t  true_up_x;
  lav_pkg::unit_t  true_up_y;
  lav_pkg::unit_t  true_up_z;
  lav_pkg::unit_t  back_x;
  lav_pkg::unit_t  back_y;
  lav_pkg::unit_t  back_z;
  lav_pkg::coord_t shift_x;
  lav_pkg::coord_t shift_y;
  lav_pkg::coord_t shift_z;

  modport source (
    output valid, side_x, side_y, side_z, true_up_x, true_up_y, true_up_z,
           back_x, back_y, back_z, shift_x, shift_y, shift_z,
    input  ready
  );
  modport sink (
    input  valid, side_x, side_y, side_z, true_up_x, true_up_y, true_up_z,
           back_x, back_y, back_z, shift_x, shift_y, shift_z,
    output ready
  );
endinterface

// ===== rtl/lav_norm.sv =====
// Pipelined vector normaliser: scale, sum of squares, square root, divide.
module lav_norm #(
  parameter int VW = 33,
  parameter int SW = 1,
  parameter int LZ = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [VW-1:0] in_v [3],
  input  logic [SW-1:0]        in_sb,
  output logic                 out_vld,
  output logic                 out_ok,
  output lav_pkg::unit_t       out_u [3],
  output logic [SW-1:0]        out_sb
);
  import lav_pkg::*;

  localparam int LAT = LZ + 56;
  localparam int CTW = SW + 4;
  localparam int ZB = SW + 3;
  localparam int DW = LEN_W + DIV_STEPS;

  logic           vld_r [LAT];
  logic [CTW-1:0] ctl_r [LAT];

  // valid bits and side data: {zero, signs, sideband}
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= {~|{in_v[0], in_v[1], in_v[2]}, in_v[2][VW-1], in_v[1][VW-1],
                   in_v[0][VW-1], in_sb};
      for (int k = 1; k < LAT; k++) ctl_r[k] <= ctl_r[k-1];
    end
  end

  // magnitudes
  logic [VW-1:0] mag0_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        mag0_r[i] <= $unsigned(in_v[i][VW-1] ? -in_v[i] : in_v[i]);
    end
  end

  // largest magnitude
  logic [VW-1:0] big0;
  always_comb begin
    big0 = mag0_r[0];
    if (mag0_r[1] > big0) big0 = mag0_r[1];
    if (mag0_r[2] > big0) big0 = mag0_r[2];
  end

  logic [VW-1:0] sh_m_r [LZ+1][3];
  logic [VW-1:0] sh_b_r [LZ];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sh_m_r[0][i] <= mag0_r[i];
      sh_b_r[0] <= big0;
    end
  end

  // left shift in halving steps until the top bit of the largest is set
  for (genvar j = 0; j < LZ; j++) begin : g_lz
    localparam int K = 1 << (LZ - 1 - j);
    if (K < VW) begin : g_sh
      logic top0;
      assign top0 = (sh_b_r[j][VW-1 -: K] == '0);
      always_ff @(posedge clk) begin
        if (en) begin
          if (j + 1 < LZ) sh_b_r[j+1] <= top0 ? (sh_b_r[j] << K) : sh_b_r[j];
          for (int i = 0; i < 3; i++)
            sh_m_r[j+1][i] <= top0 ? (sh_m_r[j][i] << K) : sh_m_r[j][i];
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          if (j + 1 < LZ) sh_b_r[j+1] <= sh_b_r[j];
          for (int i = 0; i < 3; i++) sh_m_r[j+1][i] <= sh_m_r[j][i];
        end
      end
    end
  end

  // squares of the scaled magnitudes
  logic [MANT_W-1:0]   mn_c [3];
  logic [2*MANT_W-1:0] sq_r [3];
  logic [MANT_W-1:0]   mn_r [SQRT_STEPS+2][3];

  for (genvar i = 0; i < 3; i++) begin : g_mn
    assign mn_c[i] = sh_m_r[LZ][i][VW-1 -: MANT_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i]    <= (2*MANT_W)'(mn_c[i]) * (2*MANT_W)'(mn_c[i]);
        mn_r[0][i] <= mn_c[i];
      end
      for (int k = 1; k < SQRT_STEPS + 2; k++) mn_r[k] <= mn_r[k-1];
    end
  end

  // sum of squares, then integer square root one result bit a stage
  logic [SUM_W-1:0] rs_r [SQRT_STEPS];
  logic [SUM_W-1:0] rr_r [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rs_r[0] <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
      rr_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
    logic [SUM_W-1:0] trial;
    logic             ge;
    assign trial = rr_r[k] + BIT;
    assign ge    = (rs_r[k] >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        if (k + 1 < SQRT_STEPS) rs_r[k+1] <= ge ? (rs_r[k] - trial) : rs_r[k];
        rr_r[k+1] <= ge ? ((rr_r[k] >> 1) + BIT) : (rr_r[k] >> 1);
      end
    end
  end

  // numerators with half the length added for rounding
  logic [LEN_W-1:0]     len;
  logic [NUM_W-1:0]     rem_r [DIV_STEPS][3];
  logic [DIV_STEPS-1:0] quo_r [DIV_STEPS+1][3];
  logic [LEN_W-1:0]     den_r [DIV_STEPS];

  assign len = rr_r[SQRT_STEPS][LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rem_r[0][i] <= NUM_W'({mn_r[SQRT_STEPS+1][i], {FRAC{1'b0}}}) + NUM_W'(len >> 1);
        quo_r[0][i] <= '0;
      end
      den_r[0] <= len;
    end
  end

  // restoring division, one quotient bit a stage, three lanes
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int K = DIV_STEPS - 1 - j;
    logic [DW-1:0] dsh;
    logic [DW-1:0] rx [3];
    logic          ge [3];
    assign dsh = DW'(den_r[j]) << K;
    for (genvar i = 0; i < 3; i++) begin : g_lane
      assign rx[i] = DW'(rem_r[j][i]);
      assign ge[i] = (rx[i] >= dsh);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (j + 1 < DIV_STEPS)
            rem_r[j+1][i] <= ge[i] ? NUM_W'(rx[i] - dsh) : rem_r[j][i];
          quo_r[j+1][i] <= {quo_r[j][i][DIV_STEPS-2:0], ge[i]};
        end
        if (j + 1 < DIV_STEPS) den_r[j+1] <= den_r[j];
      end
    end
  end

  // clamp to one and restore signs
  unit_t out_u_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (ctl_r[LAT-2][SW+i])
          out_u_r[i] <= -unit_t'((quo_r[DIV_STEPS][i] > ONE_Q16) ? ONE_Q16
                                                                 : quo_r[DIV_STEPS][i]);
        else
          out_u_r[i] <= unit_t'((quo_r[DIV_STEPS][i] > ONE_Q16) ? ONE_Q16
                                                               : quo_r[DIV_STEPS][i]);
      end
    end
  end

  assign out_vld = vld_r[LAT-1];
  assign out_ok  = ~ctl_r[LAT-1][ZB];
  assign out_sb  = ctl_r[LAT-1][SW-1:0];
  assign out_u   = out_u_r;

endmodule

// ===== rtl/look_at_view_matrix.sv =====
// Look-at camera setup. One word per cycle is accepted and one result word
// leaves per cycle while the output is not stalled; each word passes through
// the two normalisers in series (most of each is the 32-stage square root and
// the 18-stage divider) on its way to the output register. A stall on the output
// freezes the whole pipeline, so in_chan.ready follows out_chan.ready while a
// result is held. Zero-length direction or up hint, or an up hint parallel to
// the view direction, gives an all-zero result word.
module look_at_view_matrix (
  input  logic     clk,
  input  logic     rst_n,
  lav_in_if.sink   in_chan,
  lav_out_if.source out_chan
);
  import lav_pkg::*;

  localparam int NLZ = LZ_STEPS;
  localparam int SB_A = 2 * CW;
  localparam int SB_C = 1 + 3 * UW + 3 * CW;

  function automatic unit_t rnd_up(input logic signed [CROSS_W-1:0] v);
    logic [CROSS_W-1:0]      m;
    logic [CROSS_W-FRAC-1:0] q;
    m = $unsigned(v[CROSS_W-1] ? -v : v);
    q = (CROSS_W-FRAC)'((m + CROSS_W'(32768)) >> FRAC);
    if (q > (CROSS_W-FRAC)'(ONE_Q16)) q = (CROSS_W-FRAC)'(ONE_Q16);
    return v[CROSS_W-1] ? -unit_t'(q) : unit_t'(q);
  endfunction

  function automatic coord_t rnd_sat(input logic signed [DOT_W-1:0] v);
    logic [DOT_W-1:0]      m;
    logic [DOT_W-FRAC-1:0] q;
    m = $unsigned(v[DOT_W-1] ? -v : v);
    q = (DOT_W-FRAC)'((m + DOT_W'(32768)) >> FRAC);
    if (v[DOT_W-1]) begin
      if (q > (DOT_W-FRAC)'(33'h1_0000_0000 >> 1)) return {1'b1, {(CW-1){1'b0}}};
      return -coord_t'(q[CW-1:0]);
    end
    if (q > (DOT_W-FRAC)'({(CW-1){1'b1}})) return {1'b0, {(CW-1){1'b1}}};
    return coord_t'(q[CW-1:0]);
  endfunction

  logic en;
  assign en = ~out_chan.valid | out_chan.ready;
  assign in_chan.ready = en;

  // valid bits of the top-level stages
  logic v0_r, vc1_r, vc2_r, vd1_r, vd2_r, vd3_r, ve1_r, ve2_r, ve3_r;
  logic na_vld, nb_vld, nc_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      vc1_r <= 1'b0;
      vc2_r <= 1'b0;
      vd1_r <= 1'b0;
      vd2_r <= 1'b0;
      vd3_r <= 1'b0;
      ve1_r <= 1'b0;
      ve2_r <= 1'b0;
      ve3_r <= 1'b0;
    end else if (en) begin
      v0_r  <= in_chan.valid;
      vc1_r <= na_vld & nb_vld;
      vc2_r <= vc1_r;
      vd1_r <= nc_vld;
      vd2_r <= vd1_r;
      vd3_r <= vd2_r;
      ve1_r <= vd3_r;
      ve2_r <= ve1_r;
      ve3_r <= ve2_r;
    end
  end

  // input register: direction and up hint
  coord_t                   eye0_r [3];
  coord_t                   hint0_r [3];
  logic signed [DIR_W-1:0]  dir0_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      eye0_r[0]  <= in_chan.eye_x;
      eye0_r[1]  <= in_chan.eye_y;
      eye0_r[2]  <= in_chan.eye_z;
      hint0_r[0] <= in_chan.upvec_x;
      hint0_r[1] <= in_chan.upvec_y;
      hint0_r[2] <= in_chan.upvec_z;
      dir0_r[0]  <= DIR_W'(in_chan.target_x) - DIR_W'(in_chan.eye_x);
      dir0_r[1]  <= DIR_W'(in_chan.target_y) - DIR_W'(in_chan.eye_y);
      dir0_r[2]  <= DIR_W'(in_chan.target_z) - DIR_W'(in_chan.eye_z);
    end
  end

  // unit direction and unit up hint side by side
  unit_t           f_n [3];
  unit_t           u_n [3];
  logic            na_ok, nb_ok;
  logic [SB_A-1:0] na_sb;
  logic [CW-1:0]   nb_sb;

  lav_norm #(.VW(DIR_W), .SW(SB_A), .LZ(NLZ)) u_norm_dir (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (v0_r),
    .in_v    (dir0_r),
    .in_sb   ({eye0_r[0], eye0_r[1]}),
    .out_vld (na_vld),
    .out_ok  (na_ok),
    .out_u   (f_n),
    .out_sb  (na_sb)
  );

  lav_norm #(.VW(CW), .SW(CW), .LZ(NLZ)) u_norm_up (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (v0_r),
    .in_v    (hint0_r),
    .in_sb   (eye0_r[2]),
    .out_vld (nb_vld),
    .out_ok  (nb_ok),
    .out_u   (u_n),
    .out_sb  (nb_sb)
  );

  // side = f x u, products then differences
  logic signed [PROD_W-1:0]  c1_p_r [6];
  unit_t                     f_c1_r [3];
  coord_t                    eye_c1_r [3];
  logic                      ok_c1_r;
  logic signed [CROSS_W-1:0] sraw_r [3];
  unit_t                     f_c2_r [3];
  coord_t                    eye_c2_r [3];
  logic                      ok_c2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c1_p_r[0]   <= PROD_W'(f_n[1]) * PROD_W'(u_n[2]);
      c1_p_r[1]   <= PROD_W'(f_n[2]) * PROD_W'(u_n[1]);
      c1_p_r[2]   <= PROD_W'(f_n[2]) * PROD_W'(u_n[0]);
      c1_p_r[3]   <= PROD_W'(f_n[0]) * PROD_W'(u_n[2]);
      c1_p_r[4]   <= PROD_W'(f_n[0]) * PROD_W'(u_n[1]);
      c1_p_r[5]   <= PROD_W'(f_n[1]) * PROD_W'(u_n[0]);
      f_c1_r      <= f_n;
      eye_c1_r[0] <= na_sb[SB_A-1 -: CW];
      eye_c1_r[1] <= na_sb[CW-1:0];
      eye_c1_r[2] <= nb_sb;
      ok_c1_r     <= na_ok & nb_ok;

      for (int i = 0; i < 3; i++)
        sraw_r[i] <= CROSS_W'(c1_p_r[2*i]) - CROSS_W'(c1_p_r[2*i+1]);
      f_c2_r   <= f_c1_r;
      eye_c2_r <= eye_c1_r;
      ok_c2_r  <= ok_c1_r;
    end
  end

  // unit side vector; direction, eye and flag ride along
  unit_t           s_n [3];
  logic            nc_ok;
  logic [SB_C-1:0] nc_sb;

  lav_norm #(.VW(CROSS_W), .SW(SB_C), .LZ(NLZ)) u_norm_side (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vc2_r),
    .in_v    (sraw_r),
    .in_sb   ({ok_c2_r, f_c2_r[0], f_c2_r[1], f_c2_r[2],
               eye_c2_r[0], eye_c2_r[1], eye_c2_r[2]}),
    .out_vld (nc_vld),
    .out_ok  (nc_ok),
    .out_u   (s_n),
    .out_sb  (nc_sb)
  );

  // true up = s x f, products, differences, rounding
  logic signed [PROD_W-1:0]  d1_p_r [6];
  unit_t                     s_d1_r [3], f_d1_r [3];
  coord_t                    eye_d1_r [3];
  logic                      ok_d1_r;
  logic signed [CROSS_W-1:0] upraw_r [3];
  unit_t                     s_d2_r [3], f_d2_r [3];
  coord_t                    eye_d2_r [3];
  logic                      ok_d2_r;
  unit_t                     up_d3_r [3], s_d3_r [3], f_d3_r [3];
  coord_t                    eye_d3_r [3];
  logic                      ok_d3_r;
  unit_t                     f_sb [3];
  coord_t                    eye_sb [3];

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign f_sb[i]   = nc_sb[SB_C-2-UW*i -: UW];
    assign eye_sb[i] = nc_sb[3*CW-1-CW*i -: CW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_p_r[0] <= PROD_W'(s_n[1]) * PROD_W'(f_sb[2]);
      d1_p_r[1] <= PROD_W'(s_n[2]) * PROD_W'(f_sb[1]);
      d1_p_r[2] <= PROD_W'(s_n[2]) * PROD_W'(f_sb[0]);
      d1_p_r[3] <= PROD_W'(s_n[0]) * PROD_W'(f_sb[2]);
      d1_p_r[4] <= PROD_W'(s_n[0]) * PROD_W'(f_sb[1]);
      d1_p_r[5] <= PROD_W'(s_n[1]) * PROD_W'(f_sb[0]);
      s_d1_r    <= s_n;
      f_d1_r    <= f_sb;
      eye_d1_r  <= eye_sb;
      ok_d1_r   <= nc_ok & nc_sb[SB_C-1];

      for (int i = 0; i < 3; i++)
        upraw_r[i] <= CROSS_W'(d1_p_r[2*i]) - CROSS_W'(d1_p_r[2*i+1]);
      s_d2_r   <= s_d1_r;
      f_d2_r   <= f_d1_r;
      eye_d2_r <= eye_d1_r;
      ok_d2_r  <= ok_d1_r;

      for (int i = 0; i < 3; i++) up_d3_r[i] <= rnd_up(upraw_r[i]);
      s_d3_r   <= s_d2_r;
      f_d3_r   <= f_d2_r;
      eye_d3_r <= eye_d2_r;
      ok_d3_r  <= ok_d2_r;
    end
  end

  // translation: row dot eye, products then sums
  logic signed [DOT_P_W-1:0] e_p_r [3][3];
  unit_t                     s_e1_r [3], up_e1_r [3], f_e1_r [3];
  logic                      ok_e1_r;
  logic signed [DOT_W-1:0]   t_e2_r [3];
  unit_t                     s_e2_r [3], up_e2_r [3], f_e2_r [3];
  logic                      ok_e2_r;
  logic signed [DOT_W-1:0]   dsum [3];

  always_comb begin
    for (int r = 0; r < 3; r++)
      dsum[r] = DOT_W'(e_p_r[r][0]) + DOT_W'(e_p_r[r][1]) + DOT_W'(e_p_r[r][2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e_p_r[0][i] <= DOT_P_W'(s_d3_r[i])  * DOT_P_W'(eye_d3_r[i]);
        e_p_r[1][i] <= DOT_P_W'(up_d3_r[i]) * DOT_P_W'(eye_d3_r[i]);
        e_p_r[2][i] <= DOT_P_W'(f_d3_r[i])  * DOT_P_W'(eye_d3_r[i]);
      end
      s_e1_r  <= s_d3_r;
      up_e1_r <= up_d3_r;
      f_e1_r  <= f_d3_r;
      ok_e1_r <= ok_d3_r;

      // rows 0 and 1 negate; row 2 is -f, so its double negation cancels
      t_e2_r[0] <= -dsum[0];
      t_e2_r[1] <= -dsum[1];
      t_e2_r[2] <= dsum[2];
      s_e2_r    <= s_e1_r;
      up_e2_r   <= up_e1_r;
      f_e2_r    <= f_e1_r;
      ok_e2_r   <= ok_e1_r;
    end
  end

  // output register; degenerate input gives zeros
  always_ff @(posedge clk) begin
    if (en) begin
      if (ok_e2_r) begin
        out_chan.side_x    <= s_e2_r[0];
        out_chan.side_y    <= s_e2_r[1];
        out_chan.side_z    <= s_e2_r[2];
        out_chan.true_up_x <= up_e2_r[0];
        out_chan.true_up_y <= up_e2_r[1];
        out_chan.true_up_z <= up_e2_r[2];
        out_chan.back_x    <= -f_e2_r[0];
        out_chan.back_y    <= -f_e2_r[1];
        out_chan.back_z    <= -f_e2_r[2];
        out_chan.shift_x   <= rnd_sat(t_e2_r[0]);
        out_chan.shift_y   <= rnd_sat(t_e2_r[1]);
        out_chan.shift_z   <= rnd_sat(t_e2_r[2]);
      end else begin
        out_chan.side_x    <= '0;
        out_chan.side_y    <= '0;
        out_chan.side_z    <= '0;
        out_chan.true_up_x <= '0;
        out_chan.true_up_y <= '0;
        out_chan.true_up_z <= '0;
        out_chan.back_x    <= '0;
        out_chan.back_y    <= '0;
        out_chan.back_z    <= '0;
        out_chan.shift_x   <= '0;
        out_chan.shift_y   <= '0;
        out_chan.shift_z   <= '0;
      end
    end
  end

  assign out_chan.valid = ve3_r;

`ifndef SYNTHESIS
  // the two first normalisers must stay in lock step
  a_norm_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    na_vld == nb_vld)
    else $error("direction and up normalisers out of step");

  // a zero side row only comes with zero back and shift fields
  a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.side_x == '0 && out_chan.side_y == '0 &&
     out_chan.side_z == '0) |->
    (out_chan.back_x == '0 && out_chan.back_y == '0 && out_chan.back_z == '0 &&
     out_chan.shift_x == '0 && out_chan.shift_y == '0 && out_chan.shift_z == '0))
    else $error("zero side row with non-zero word");

  // the back_x unit component never exceeds one in magnitude
  a_back_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.back_x <= $signed(UW'(65536)) &&
                        out_chan.back_x >= -$signed(UW'(65536))))
    else $error("back_x out of unit range");

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("result valid straight after reset");
`endif

endmodule
